/* design/mdob_pkg.sv */
// ----------------------------------------------------------------------------
// mdob_pkg
// Shared types, constants and fixed-point helpers for the motor disturbance
// observer: controller states, datapath commands and rounding/saturation.
// ----------------------------------------------------------------------------
package mdob_pkg;

  localparam int DataW   = 32;
  localparam int CfgIdxW = 8;
  localparam int AccW    = 42;
  localparam int DWideW  = 49;

  localparam logic signed [DataW-1:0] DeadbandRaw = 32'sd65;

  localparam logic [CfgIdxW-1:0] CfgCoefDecay       = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgCoefCurrentGain = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgCoefTorqueGain  = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgCoulombTerm     = 8'd3;
  localparam logic [CfgIdxW-1:0] CfgObserverGain    = 8'd4;
  localparam logic [CfgIdxW-1:0] CfgTorqueLimit     = 8'd5;
  localparam logic [CfgIdxW-1:0] CfgCurrentLimit    = 8'd6;
  localparam logic [CfgIdxW-1:0] CfgInvTorqueConst  = 8'd7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BYPASS,
    S_MUL_DECAY,
    S_MUL_CUR,
    S_MUL_TRQ,
    S_ADD_TRQ,
    S_PRED,
    S_RESID,
    S_MUL_OBS,
    S_UPD_D,
    S_MUL_FF,
    S_FF,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    MSEL_DECAY,
    MSEL_CUR,
    MSEL_TRQ,
    MSEL_OBS,
    MSEL_FF
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_clr;
    logic     acc_add;
    logic     pred;
    logic     resid;
    logic     upd_dist;
    logic     calc_ff;
    logic     bypass;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic obs_zero;
    logic bypass;
  } sts_t;

  // round to nearest, ties up, then shift right by 24
  function automatic logic signed [39:0] rnd_shr24(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd8388608;
    return s[63:24];
  endfunction

  // round to nearest, ties up, then shift right by 16
  function automatic logic signed [47:0] rnd_shr16(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd32768;
    return s[63:16];
  endfunction

  function automatic logic signed [DataW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(32'sh7fffffff);
    lo = AccW'(32'sh80000000);
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[DataW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] clamp_sym(input logic signed [DWideW-1:0] v,
                                                       input logic [30:0] lim);
    logic signed [DWideW-1:0] pos;
    logic signed [DWideW-1:0] neg;
    pos = signed'({18'd0, lim});
    neg = -pos;
    if (v > pos) begin
      return pos[DataW-1:0];
    end else if (v < neg) begin
      return neg[DataW-1:0];
    end
    return v[DataW-1:0];
  endfunction

endpackage

/* design/motor_disturbance_observer.sv */
// ----------------------------------------------------------------------------
// motor_disturbance_observer
// First-order velocity disturbance observer with coulomb friction and a
// clamped current feedforward, in Q16.16 with Q8.24 model coefficients.
// ----------------------------------------------------------------------------
// usage:
//   input word (op, measured_speed, commanded_current) is taken on
//   in_valid && !in_stall; one result word (feedforward_current,
//   speed_residual, disturbance_estimate) leaves on out_valid && !out_stall.
//   the block holds one word at a time; a single signed 32x32 multiplier
//   with a registered product is used for all five products in turn, and the
//   next word is taken only once the last result is loaded for output. a zero
//   observer gain skips the observer product and estimate update; an op=1
//   word skips the multiplier and goes straight to the result.
//   configuration is written on cfg_valid (cfg_ready is always high); the
//   user must write it only while no word is in flight, which the block does
//   not enforce. indexes beyond the register list are dropped.
//   reset loads the register defaults and zeroes model speed and estimate;
//   no result is pending after reset. while out_stall holds a result, the
//   next word is computed and then waits until the result is taken.
// ----------------------------------------------------------------------------
module motor_disturbance_observer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mdob_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [mdob_pkg::DataW-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic signed [mdob_pkg::DataW-1:0] measured_speed,
  input  logic signed [mdob_pkg::DataW-1:0] commanded_current,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [mdob_pkg::DataW-1:0] feedforward_current,
  output logic signed [mdob_pkg::DataW-1:0] speed_residual,
  output logic signed [mdob_pkg::DataW-1:0] disturbance_estimate
);
  import mdob_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  mdob_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_op     (op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mdob_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_op      (op),
    .in_speed   (measured_speed),
    .in_current (commanded_current),
    .cmd        (cmd),
    .sts        (sts),
    .out_ff     (feedforward_current),
    .out_resid  (speed_residual),
    .out_dist   (disturbance_estimate)
  );

  // one word in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("word taken while another is in flight");

  // loading a result publishes it and frees the input side
  a_load_publishes: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (out_valid && !in_stall))
    else $error("result load did not raise out_valid");

  // bypass words give all-zero results
  a_bypass_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && sts.bypass) |=>
      (feedforward_current == '0 && speed_residual == '0 && disturbance_estimate == '0))
    else $error("bypass result not zero");

endmodule

/* design/mdob_ctrl.sv */
// ----------------------------------------------------------------------------
// mdob_ctrl
// Sequencer for the observer: accepts one word, steps observe words through
// the shared multiplier (bypass words skip it), then hands the result to the output register.
// ----------------------------------------------------------------------------
module mdob_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_op,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  mdob_pkg::sts_t sts,
  output mdob_pkg::cmd_t cmd
);
  import mdob_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = in_op ? S_BYPASS : S_MUL_DECAY;
        end
      end
      S_BYPASS:    state_next = S_OUT;
      S_MUL_DECAY: state_next = S_MUL_CUR;
      S_MUL_CUR:   state_next = S_MUL_TRQ;
      S_MUL_TRQ:   state_next = S_ADD_TRQ;
      S_ADD_TRQ:   state_next = S_PRED;
      S_PRED:      state_next = S_RESID;
      S_RESID:     state_next = sts.obs_zero ? S_MUL_FF : S_MUL_OBS;
      S_MUL_OBS:   state_next = S_UPD_D;
      S_UPD_D:     state_next = S_MUL_FF;
      S_MUL_FF:    state_next = S_FF;
      S_FF:        state_next = S_OUT;
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.mul_sel = MSEL_DECAY;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      S_BYPASS:    cmd.bypass = 1'b1;
      S_MUL_DECAY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_DECAY;
        cmd.acc_clr = 1'b1;
      end
      S_MUL_CUR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_CUR;
        cmd.acc_add = 1'b1;
      end
      S_MUL_TRQ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_TRQ;
        cmd.acc_add = 1'b1;
      end
      S_ADD_TRQ:   cmd.acc_add = 1'b1;
      S_PRED:      cmd.pred = 1'b1;
      S_RESID:     cmd.resid = 1'b1;
      S_MUL_OBS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_OBS;
      end
      S_UPD_D:     cmd.upd_dist = 1'b1;
      S_MUL_FF: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_FF;
      end
      S_FF:        cmd.calc_ff = 1'b1;
      S_OUT:       cmd.load_out = !out_valid || !out_stall;
      default:     cmd = '0;
    endcase
  end

endmodule

/* design/mdob_dp.sv */
// ----------------------------------------------------------------------------
// mdob_dp
// Observer datapath: configuration registers, observer state, one shared
// 32x32 multiplier with a registered product, accumulator and output words.
// ----------------------------------------------------------------------------
module mdob_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr,
  input  logic [mdob_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [mdob_pkg::DataW-1:0]          cfg_data,
  input  logic                                in_op,
  input  logic signed [mdob_pkg::DataW-1:0]   in_speed,
  input  logic signed [mdob_pkg::DataW-1:0]   in_current,
  input  mdob_pkg::cmd_t                      cmd,
  output mdob_pkg::sts_t                      sts,
  output logic signed [mdob_pkg::DataW-1:0]   out_ff,
  output logic signed [mdob_pkg::DataW-1:0]   out_resid,
  output logic signed [mdob_pkg::DataW-1:0]   out_dist
);
  import mdob_pkg::*;

  logic [24:0] coef_decay;
  logic [30:0] coef_current_gain;
  logic [30:0] coef_torque_gain;
  logic [30:0] coulomb_speed_term;
  logic [30:0] observer_gain;
  logic [30:0] torque_limit;
  logic [30:0] current_limit;
  logic [30:0] inverse_torque_constant;

  logic                     op;
  logic signed [DataW-1:0]  meas;
  logic signed [DataW-1:0]  cur;
  logic signed [DataW-1:0]  model_speed;
  logic signed [DataW-1:0]  dist_torque;
  logic signed [DataW-1:0]  resid;
  logic signed [DataW-1:0]  ff;
  logic signed [63:0]       prod;
  logic signed [AccW-1:0]   acc;

  logic signed [DataW-1:0]  mul_a;
  logic signed [DataW-1:0]  mul_b;
  logic signed [63:0]       mul_p;
  logic                     fric_pos;
  logic                     fric_neg;
  logic signed [AccW-1:0]   coul_ext;
  logic signed [AccW-1:0]   pred_wide;
  logic signed [AccW-1:0]   resid_wide;
  logic signed [DWideW-1:0] d_wide;
  logic signed [DWideW-1:0] ff_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_decay              <= 25'd16777216;
      coef_current_gain       <= '0;
      coef_torque_gain        <= '0;
      coulomb_speed_term      <= '0;
      observer_gain           <= '0;
      torque_limit            <= 31'd65536;
      current_limit           <= 31'd65536;
      inverse_torque_constant <= 31'd65536;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CfgCoefDecay:       coef_decay              <= cfg_data[24:0];
        CfgCoefCurrentGain: coef_current_gain       <= cfg_data[30:0];
        CfgCoefTorqueGain:  coef_torque_gain        <= cfg_data[30:0];
        CfgCoulombTerm:     coulomb_speed_term      <= cfg_data[30:0];
        CfgObserverGain:    observer_gain           <= cfg_data[30:0];
        CfgTorqueLimit:     torque_limit            <= cfg_data[30:0];
        CfgCurrentLimit:    current_limit           <= cfg_data[30:0];
        CfgInvTorqueConst:  inverse_torque_constant <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      MSEL_DECAY: begin
        mul_a = signed'({7'd0, coef_decay});
        mul_b = model_speed;
      end
      MSEL_CUR: begin
        mul_a = signed'({1'b0, coef_current_gain});
        mul_b = cur;
      end
      MSEL_TRQ: begin
        mul_a = signed'({1'b0, coef_torque_gain});
        mul_b = dist_torque;
      end
      MSEL_OBS: begin
        mul_a = signed'({1'b0, observer_gain});
        mul_b = resid;
      end
      MSEL_FF: begin
        mul_a = signed'({1'b0, inverse_torque_constant});
        mul_b = dist_torque;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // coulomb sign, measured speed breaks the tie inside the deadband
  always_comb begin
    fric_pos = (model_speed > DeadbandRaw) ||
               (!(model_speed < -DeadbandRaw) && (meas > DeadbandRaw));
    fric_neg = (model_speed < -DeadbandRaw) ||
               (!(model_speed > DeadbandRaw) && (meas < -DeadbandRaw));
    coul_ext = signed'({{(AccW-31){1'b0}}, coulomb_speed_term});
    if (fric_pos) begin
      pred_wide = acc - coul_ext;
    end else if (fric_neg) begin
      pred_wide = acc + coul_ext;
    end else begin
      pred_wide = acc;
    end
    resid_wide = AccW'(meas) - acc;
    d_wide     = DWideW'(dist_torque) + DWideW'(rnd_shr16(prod));
    ff_wide    = -DWideW'(rnd_shr16(prod));
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op   <= in_op;
      meas <= in_speed;
      cur  <= in_current;
    end
    if (cmd.mul_en) begin
      prod <= mul_p;
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + AccW'(rnd_shr24(prod));
    end else if (cmd.pred) begin
      acc <= AccW'(sat32(pred_wide));
    end
    if (cmd.resid) begin
      resid <= sat32(resid_wide);
    end else if (cmd.bypass) begin
      resid <= '0;
    end
    if (cmd.calc_ff) begin
      ff <= clamp_sym(ff_wide, current_limit);
    end else if (cmd.bypass) begin
      ff <= '0;
    end
    if (cmd.load_out) begin
      out_ff    <= ff;
      out_resid <= resid;
      out_dist  <= dist_torque;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      model_speed <= '0;
      dist_torque <= '0;
    end else begin
      if (cmd.bypass || cmd.calc_ff) begin
        model_speed <= meas;
      end
      if (cmd.bypass) begin
        dist_torque <= '0;
      end else if (cmd.upd_dist) begin
        dist_torque <= clamp_sym(d_wide, torque_limit);
      end
    end
  end

  assign sts.obs_zero = (observer_gain == '0);
  assign sts.bypass   = op;

endmodule

/* sim/motor_disturbance_observer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_disturbance_observer_tb
// Self-checking bench for the disturbance observer. A walked table of
// directed words and register writes runs first, then random phases, each
// with its own register setting. Every result word is checked field by
// field against a built-in fixed-point predictor of the observer or its
// typed table values, with random idle and stall on both channels.
// ----------------------------------------------------------------------------
module motor_disturbance_observer_tb;
  import mdob_pkg::*;

  localparam logic OP_OBSERVE      = 1'b0;
  localparam logic OP_BYPASS       = 1'b1;
  localparam int   LONG_HOLD       = 400;
  localparam int   RAND_PHASES     = 8;
  localparam int   WORDS_PER_PHASE = 100;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic signed [DataW-1:0] ff;
    logic signed [DataW-1:0] resid;
    logic signed [DataW-1:0] dist_est;
  } observer_out_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [CfgIdxW-1:0]  idx;
    logic                op_w;
    logic [DataW-1:0]    a;
    logic [DataW-1:0]    b;
    logic                typed;
    observer_out_t       want;
  } dir_row_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CfgIdxW-1:0]       cfg_index;
  logic [DataW-1:0]         cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic                     op;
  logic signed [DataW-1:0]  measured_speed;
  logic signed [DataW-1:0]  commanded_current;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DataW-1:0]  feedforward_current;
  logic signed [DataW-1:0]  speed_residual;
  logic signed [DataW-1:0]  disturbance_estimate;

  // predictor copy of the registers and the observer state
  logic [24:0]              r_decay    = 25'h100_0000;
  logic [30:0]              r_cur_gain = '0;
  logic [30:0]              r_trq_gain = '0;
  logic [30:0]              r_coulomb  = '0;
  logic [30:0]              r_obs_gain = '0;
  logic [30:0]              r_trq_lim  = 31'h1_0000;
  logic [30:0]              r_cur_lim  = 31'h1_0000;
  logic [30:0]              r_inv_kt   = 31'h1_0000;
  logic signed [DataW-1:0]  model_spd  = '0;
  logic signed [DataW-1:0]  dist_trq   = '0;

  observer_out_t pending_outputs[$];
  dir_row_t      dir_rows[$];
  int            mismatches  = 0;
  int            stall_left  = 0;
  bit            hold_request = 1'b0;
  bit            calm        = 1'b0;

  motor_disturbance_observer dut (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .op                   (op),
    .measured_speed       (measured_speed),
    .commanded_current    (commanded_current),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .feedforward_current  (feedforward_current),
    .speed_residual       (speed_residual),
    .disturbance_estimate (disturbance_estimate)
  );

  function automatic longint round_shift(longint p, int s);
    return (p + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [DataW-1:0] sat_word(longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[DataW-1:0];
  endfunction

  function automatic longint clamp_to_limit(longint v, logic [30:0] lim);
    longint l;
    l = longint'(lim);
    if (v > l) begin
      return l;
    end
    if (v < -l) begin
      return -l;
    end
    return v;
  endfunction

  function automatic int friction_sign(logic signed [DataW-1:0] v);
    if (v > DeadbandRaw) begin
      return 1;
    end
    if (v < -DeadbandRaw) begin
      return -1;
    end
    return 0;
  endfunction

  function automatic observer_out_t predict_observer_step(logic op_w,
                                                          logic signed [DataW-1:0] meas,
                                                          logic signed [DataW-1:0] cur);
    observer_out_t           r;
    int                      sgn;
    longint                  pred;
    longint                  d;
    logic signed [DataW-1:0] resid;
    r = '0;
    if (op_w == OP_BYPASS) begin
      model_spd = meas;
      dist_trq  = '0;
      return r;
    end
    sgn = friction_sign(model_spd);
    if (sgn == 0) begin
      sgn = friction_sign(meas);
    end
    pred = round_shift(longint'(r_decay) * longint'(model_spd), 24)
         + round_shift(longint'(r_cur_gain) * longint'(cur), 24)
         + round_shift(longint'(r_trq_gain) * longint'(dist_trq), 24)
         - longint'(sgn) * longint'(r_coulomb);
    resid = sat_word(longint'(meas) - longint'(sat_word(pred)));
    if (r_obs_gain != '0) begin
      d = longint'(dist_trq) + round_shift(longint'(r_obs_gain) * longint'(resid), 16);
      d = clamp_to_limit(d, r_trq_lim);
      dist_trq = d[DataW-1:0];
    end
    d = -round_shift(longint'(r_inv_kt) * longint'(dist_trq), 16);
    d = clamp_to_limit(d, r_cur_lim);
    r.ff       = d[DataW-1:0];
    r.resid    = resid;
    r.dist_est = dist_trq;
    model_spd = meas;
    return r;
  endfunction

  function automatic dir_row_t word_row(logic op_w, logic [DataW-1:0] a, logic [DataW-1:0] b);
    dir_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.op_w = op_w;
    r.a    = a;
    r.b    = b;
    return r;
  endfunction

  function automatic dir_row_t checked_row(logic op_w, logic [DataW-1:0] a,
                                           logic [DataW-1:0] b, logic [DataW-1:0] ff,
                                           logic [DataW-1:0] resid,
                                           logic [DataW-1:0] dist_est);
    dir_row_t r;
    r = word_row(op_w, a, b);
    r.typed         = 1'b1;
    r.want.ff       = ff;
    r.want.resid    = resid;
    r.want.dist_est = dist_est;
    return r;
  endfunction

  function automatic dir_row_t reg_row(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] data);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.a    = data;
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic note_mismatch(string what, observer_out_t want, observer_out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: ff exp %h got %h, resid exp %h got %h, dist exp %h got %h",
               $realtime, what, want.ff, got.ff, want.resid, got.resid,
               want.dist_est, got.dist_est);
    end
  endtask

  task automatic idle_sender(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid          <= 1'b0;
      op                <= 1'($urandom);
      measured_speed    <= $urandom;
      commanded_current <= $urandom;
    end
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 99) < 35) begin
      idle_sender(gap_len());
    end
  endtask

  task automatic send_word(logic op_w, logic [DataW-1:0] ms, logic [DataW-1:0] cc,
                           logic typed, observer_out_t typed_out);
    observer_out_t pred;
    @(negedge clk);
    in_valid          <= 1'b1;
    op                <= op_w;
    measured_speed    <= ms;
    commanded_current <= cc;
    do @(posedge clk); while (!(in_valid && !in_stall));
    pred = predict_observer_step(op_w, ms, cc);
    pending_outputs.push_back(typed ? typed_out : pred);
  endtask

  task automatic wait_drained();
    idle_sender(1);
    while (pending_outputs.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      CfgCoefDecay:       r_decay    = data[24:0];
      CfgCoefCurrentGain: r_cur_gain = data[30:0];
      CfgCoefTorqueGain:  r_trq_gain = data[30:0];
      CfgCoulombTerm:     r_coulomb  = data[30:0];
      CfgObserverGain:    r_obs_gain = data[30:0];
      CfgTorqueLimit:     r_trq_lim  = data[30:0];
      CfgCurrentLimit:    r_cur_lim  = data[30:0];
      CfgInvTorqueConst:  r_inv_kt   = data[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [DataW-1:0] extreme31();
    return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h0;
  endfunction

  task automatic program_phase(int style);
    logic [DataW-1:0] v [8];
    case (style)
      1: begin
        foreach (v[i]) v[i] = $urandom;
      end
      2: begin
        case ($urandom_range(0, 2))
          0:       v[0] = 32'h0;
          1:       v[0] = 32'h100_0000;
          default: v[0] = 32'h1ff_ffff;
        endcase
        for (int i = 1; i < 8; i++) v[i] = extreme31();
      end
      default: begin
        v[0] = 32'h100_0000 - $urandom_range(0, 1 << 20);
        v[1] = $urandom_range(0, 1 << 22);
        v[2] = $urandom_range(0, 1 << 22);
        v[3] = $urandom_range(0, 1 << 14);
        v[4] = (style == 3 && $urandom_range(0, 1)) ? 32'h0 : $urandom_range(1, 1 << 18);
        v[5] = $urandom_range(1 << 16, 1 << 22);
        v[6] = $urandom_range(1 << 16, 1 << 22);
        v[7] = $urandom_range(1 << 14, 1 << 18);
      end
    endcase
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CfgIdxW'($urandom_range(CfgInvTorqueConst + 1, 255)), $urandom);
    end
    write_reg(CfgCoefDecay,       v[0]);
    write_reg(CfgCoefCurrentGain, v[1]);
    write_reg(CfgCoefTorqueGain,  v[2]);
    write_reg(CfgCoulombTerm,     v[3]);
    write_reg(CfgObserverGain,    v[4]);
    write_reg(CfgTorqueLimit,     v[5]);
    write_reg(CfgCurrentLimit,    v[6]);
    write_reg(CfgInvTorqueConst,  v[7]);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver stall bursts, one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < 20) begin
        stall_left = gap_len();
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) begin
        stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    observer_out_t got;
    observer_out_t want;
    if (!rst && out_valid && !out_stall) begin
      got.ff       = feedforward_current;
      got.resid    = speed_residual;
      got.dist_est = disturbance_estimate;
      if (pending_outputs.size() == 0) begin
        note_mismatch("unexpected result word", '0, got);
      end else begin
        want = pending_outputs.pop_front();
        if (got.ff !== want.ff || got.resid !== want.resid ||
            got.dist_est !== want.dist_est) begin
          note_mismatch("result word mismatch", want, got);
        end
      end
    end
  end

  initial begin
    logic signed [DataW-1:0] ms_track;
    logic [DataW-1:0]        ms;
    logic [DataW-1:0]        cc;
    logic                    op_w;
    int                      r;
    rst               = 1'b1;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_valid          = 1'b0;
    op                = OP_OBSERVE;
    measured_speed    = '0;
    commanded_current = '0;

    dir_rows = '{
      // reset setting: unit decay, zero gains
      checked_row(OP_OBSERVE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0),
      checked_row(OP_OBSERVE, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h0),
      checked_row(OP_OBSERVE, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h0),
      checked_row(OP_BYPASS, 32'h1234_5678, 32'hdead_beef, 32'h0, 32'h0, 32'h0),
      checked_row(OP_OBSERVE, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 32'h0),
      reg_row(CfgCoefCurrentGain, 32'h0100_0000),
      reg_row(CfgCoefTorqueGain, 32'h0080_0000),
      reg_row(CfgCoulombTerm, 32'h0000_8000),
      reg_row(CfgObserverGain, 32'h0000_4000),
      reg_row(CfgTorqueLimit, 32'h0002_0000),
      reg_row(CfgCurrentLimit, 32'h0001_8000),
      reg_row(CfgInvTorqueConst, 32'h0002_0000),
      reg_row(CfgInvTorqueConst + 8'd1, 32'hffff_ffff),
      reg_row({CfgIdxW{1'b1}}, 32'h0),
      // friction deadband edges from model speed and from measured speed
      checked_row(OP_BYPASS, 32'd66, 32'h0, 32'h0, 32'h0, 32'h0),
      word_row(OP_OBSERVE, 32'd65, 32'h0001_0000),
      word_row(OP_OBSERVE, 32'hffff_ffbe, 32'hffff_0000),
      word_row(OP_OBSERVE, 32'h0, 32'h0),
      word_row(OP_OBSERVE, 32'hffff_ffbf, 32'h0),
      word_row(OP_OBSERVE, 32'd65, 32'h0),
      word_row(OP_OBSERVE, 32'd66, 32'h7fff_ffff),
      word_row(OP_OBSERVE, 32'h8000_0000, 32'h8000_0000),
      // zero torque limit, then zero current limit
      reg_row(CfgTorqueLimit, 32'h0),
      word_row(OP_OBSERVE, 32'h0010_0000, 32'h0000_0100),
      reg_row(CfgCurrentLimit, 32'h0),
      reg_row(CfgTorqueLimit, 32'h7fff_ffff),
      word_row(OP_OBSERVE, 32'h4000_0000, 32'h0),
      word_row(OP_OBSERVE, 32'hc000_0000, 32'h0),
      // frozen estimate, decay above one, all gains at full scale
      reg_row(CfgObserverGain, 32'h0),
      reg_row(CfgCoefDecay, 32'h01ff_ffff),
      reg_row(CfgCurrentLimit, 32'h7fff_ffff),
      reg_row(CfgCoefCurrentGain, 32'h7fff_ffff),
      reg_row(CfgCoefTorqueGain, 32'h7fff_ffff),
      reg_row(CfgCoulombTerm, 32'h7fff_ffff),
      reg_row(CfgInvTorqueConst, 32'h7fff_ffff),
      word_row(OP_OBSERVE, 32'h7fff_ffff, 32'h7fff_ffff),
      word_row(OP_OBSERVE, 32'h8000_0000, 32'h8000_0000),
      word_row(OP_OBSERVE, 32'h0001_0000, 32'hffff_0000),
      reg_row(CfgObserverGain, 32'hffff_ffff),
      word_row(OP_OBSERVE, 32'h7fff_ffff, 32'h8000_0000),
      word_row(OP_OBSERVE, 32'h8000_0000, 32'h7fff_ffff),
      checked_row(OP_BYPASS, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0)
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(dir_rows[i].idx, dir_rows[i].a);
      end else begin
        maybe_gap();
        send_word(dir_rows[i].op_w, dir_rows[i].a, dir_rows[i].b,
                  dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      wait_drained();
      calm = (phase == 2);
      program_phase(phase % 4);
      if (phase == 3) begin
        hold_request = 1'b1;
      end
      ms_track = $urandom_range(0, 1 << 20) - (1 << 19);
      send_word(OP_BYPASS, ms_track, $urandom, 1'b0, '0);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (phase == 5 && n == WORDS_PER_PHASE / 2) begin
          wait_drained();
        end
        r    = $urandom_range(0, 99);
        op_w = OP_OBSERVE;
        if (r < 5) begin
          op_w     = OP_BYPASS;
          ms_track = $urandom;
          ms       = ms_track;
          cc       = $urandom;
        end else if (r < 15) begin
          // noise word
          op_w = 1'($urandom);
          ms   = $urandom;
          cc   = $urandom;
        end else if (r < 22) begin
          ms_track = int'($urandom_range(0, 200)) - 100;
          ms       = ms_track;
          cc       = int'($urandom_range(0, 1 << 20)) - (1 << 19);
        end else begin
          ms_track = ms_track + (int'($urandom_range(0, 8191)) - 4096);
          ms       = ms_track;
          cc       = int'($urandom_range(0, 1 << 20)) - (1 << 19);
        end
        maybe_gap();
        send_word(op_w, ms, cc, 1'b0, '0);
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_outputs.size() != 0) begin
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
